[hdl/hsa_pkg.sv]
`default_nettype none
package hsa_pkg;

  localparam int SAT_FULL = 25600;
  localparam int HUE_SECT = 15360;
  localparam int HUE_FULL = 92160;

  // dividend width and quotient bits resolved per divider stage
  localparam int DIV_DVD_W = 24;
  localparam int DIV_STEP  = 4;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_SET   = 2'd1,
    MODE_SCALE = 2'd2,
    MODE_KEEP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    HB_RED   = 2'd0,
    HB_GREEN = 2'd1,
    HB_BLUE  = 2'd2
  } hue_base_t;

  localparam logic REG_AMOUNT = 1'b0;
  localparam logic REG_MODE   = 1'b1;

  typedef struct packed {
    logic [14:0] v;
    logic [7:0]  alpha;
    hue_base_t   base;
    logic        grey;
  } hsa_front_t;

  typedef struct packed {
    logic [14:0] v;
    logic [7:0]  alpha;
    logic [16:0] hue;
  } hsa_carry_t;

  // value in q8 percent from the max channel: mx * 25600 / 255
  // split as mx * 100 + mx * 100 / 255, the last through a shift-add
  function automatic logic [14:0] value_of(input logic [7:0] mx);
    logic [14:0] x;
    x = 15'(mx) * 15'd100;
    // exact x / 255 for x up to 25500, the largest mx * 100
    return x + ((x + {8'b0, x[14:8]} + 15'd1) >> 8);
  endfunction

endpackage
`default_nettype wire

[hdl/hsa_in_if.sv]
`default_nettype none
interface hsa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;
  modport source(output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink(input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface
`default_nettype wire

[hdl/hsa_out_if.sv]
`default_nettype none
interface hsa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  modport source(output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink(input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface
`default_nettype wire

[hdl/hsa_cfg_if.sv]
`default_nettype none
interface hsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [10:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/hsv_saturation_adjust.sv]
// channel   handshake        payload
// in_pix    valid / ready    red_in, green_in, blue_in, alpha_in (8 bits each)
// out_pix   valid / ready    red_out, green_out, blue_out, alpha_out (8 bits each)
// cfg_wr    valid / ready    index (0 amount, 1 mode), data (11 bits)
//
// one pixel per clock while out_pix is not stalled; of the pipeline stages,
// the two 24-bit dividers take ceil(24 / DIV_STEP) stages
// the whole pipeline advances together and holds when out_pix is stalled
// reset clears valid bits and sets amount and mode to zero
// cfg_wr is always ready
`default_nettype none
module hsv_saturation_adjust #(
  parameter int DIV_STEP = hsa_pkg::DIV_STEP
) (
  input logic        clk,
  input logic        rst_n,
  hsa_in_if.sink     in_pix,
  hsa_out_if.source  out_pix,
  hsa_cfg_if.sink    cfg_wr
);
  import hsa_pkg::*;

  localparam int FSIDE_W = $bits(hsa_front_t);

  logic               en;
  logic signed [10:0] amount_r;
  mode_t              mode_r;

  logic [7:0]  mx, mn, dd;
  hue_base_t   base;
  logic signed [8:0] num;

  logic              f_vld_r;
  logic [DIV_DVD_W-1:0] f_dvd_s_r, f_dvd_h_r;
  logic [7:0]        f_mx_r, f_d_r;
  logic              f_neg_r;
  hsa_front_t        f_front_r;

  logic                 ds_vld, dh_vld;
  logic [DIV_DVD_W-1:0] quo_s, quo_h;
  logic [7:0]           rem_s, rem_h;
  logic [FSIDE_W-1:0]   side_s;
  logic [0:0]           side_h;
  hsa_front_t           d_front;

  logic               h_vld_r;
  logic [14:0]        h_s_r;
  hsa_carry_t         h_carry_r;
  logic signed [15:0] term;
  logic signed [17:0] hsum;
  logic [16:0]        hue_nxt;

  logic        sat_vld;
  logic [14:0] sat_s;
  hsa_carry_t  sat_carry;
  logic        rgb_vld;

  assign en           = !rgb_vld || out_pix.ready;
  assign in_pix.ready = en;
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amount_r <= '0;
      mode_r   <= MODE_ADD;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_AMOUNT: amount_r <= $signed(cfg_wr.data);
        REG_MODE:   mode_r   <= mode_t'(cfg_wr.data[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    mx = in_pix.red_in;
    mn = in_pix.red_in;
    if (in_pix.green_in > mx) mx = in_pix.green_in;
    if (in_pix.blue_in > mx)  mx = in_pix.blue_in;
    if (in_pix.green_in < mn) mn = in_pix.green_in;
    if (in_pix.blue_in < mn)  mn = in_pix.blue_in;
    dd = mx - mn;
    if (mx == in_pix.red_in) begin
      base = HB_RED;
      num  = $signed({1'b0, in_pix.green_in}) - $signed({1'b0, in_pix.blue_in});
    end else if (mx == in_pix.green_in) begin
      base = HB_GREEN;
      num  = $signed({1'b0, in_pix.blue_in}) - $signed({1'b0, in_pix.red_in});
    end else begin
      base = HB_BLUE;
      num  = $signed({1'b0, in_pix.red_in}) - $signed({1'b0, in_pix.green_in});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= in_pix.valid;
    end
  end

  // s = d * 25600 / mx and hue offset = |num| * 15360 / d
  always_ff @(posedge clk) begin
    if (en) begin
      f_dvd_s_r       <= {1'b0, 13'(dd) * 13'd25, 10'b0};
      f_dvd_h_r       <= {2'b0, 12'(num[8] ? 8'(-num) : num[7:0]) * 12'd15, 10'b0};
      f_mx_r          <= mx;
      f_d_r           <= dd;
      f_neg_r         <= num[8];
      f_front_r.v     <= value_of(mx);
      f_front_r.alpha <= in_pix.alpha_in;
      f_front_r.base  <= base;
      f_front_r.grey  <= (dd == 8'd0);
    end
  end

  hsa_div #(
    .DVD_W(DIV_DVD_W), .DVS_W(8), .STEP(DIV_STEP), .SIDE_W(FSIDE_W)
  ) u_div_s (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(f_vld_r),
    .dvd(f_dvd_s_r), .dvs(f_mx_r), .side_in(f_front_r),
    .out_vld(ds_vld), .quo(quo_s), .rem(rem_s), .side_out(side_s)
  );

  hsa_div #(
    .DVD_W(DIV_DVD_W), .DVS_W(8), .STEP(DIV_STEP), .SIDE_W(1)
  ) u_div_h (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(f_vld_r),
    .dvd(f_dvd_h_r), .dvs(f_d_r), .side_in(f_neg_r),
    .out_vld(dh_vld), .quo(quo_h), .rem(rem_h), .side_out(side_h)
  );

  assign d_front = hsa_front_t'(side_s);

  // floor toward minus infinity for a negative numerator
  always_comb begin
    if (side_h[0]) begin
      term = -$signed({2'b0, quo_h[13:0]}) - $signed({15'b0, rem_h != 8'd0});
    end else begin
      term = $signed({2'b0, quo_h[13:0]});
    end
    case (d_front.base)
      HB_GREEN: hsum = 18'sd30720 + 18'(term);
      HB_BLUE:  hsum = 18'sd61440 + 18'(term);
      default:  hsum = 18'(term);
    endcase
    if (hsum < 0) begin
      hsum = hsum + 18'(HUE_FULL);
    end
    hue_nxt = d_front.grey ? '0 : hsum[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else if (en) begin
      h_vld_r <= ds_vld && dh_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_s_r           <= d_front.grey ? '0 : quo_s[14:0];
      h_carry_r.v     <= d_front.v;
      h_carry_r.alpha <= d_front.alpha;
      h_carry_r.hue   <= hue_nxt;
    end
  end

  hsa_sat u_sat (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(h_vld_r),
    .s_in(h_s_r), .carry_in(h_carry_r), .amount(amount_r), .mode(mode_r),
    .out_vld(sat_vld), .s_out(sat_s), .carry_out(sat_carry)
  );

  hsa_rgb u_rgb (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(sat_vld),
    .s_in(sat_s), .carry_in(sat_carry),
    .out_vld(rgb_vld), .red(out_pix.red_out), .green(out_pix.green_out),
    .blue(out_pix.blue_out), .alpha(out_pix.alpha_out)
  );

  assign out_pix.valid = rgb_vld;

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pix.valid && !out_pix.ready) |-> !in_pix.ready)
    else $error("input taken while output stalled");

  a_grey_hue_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ds_vld && d_front.grey) |-> (hue_nxt == 17'd0))
    else $error("grey pixel with nonzero hue");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    sat_vld |-> (sat_s <= 15'd25600))
    else $error("saturation out of range");

  a_div_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    ds_vld == dh_vld)
    else $error("divider pipelines out of step");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    h_vld_r |-> (h_carry_r.hue < 17'd92160))
    else $error("hue out of range");
endmodule
`default_nettype wire

[hdl/hsa_div.sv]
`default_nettype none
module hsa_div #(
  parameter int DVD_W  = 24,
  parameter int DVS_W  = 8,
  parameter int STEP   = 4,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [DVD_W-1:0]  dvd,
  input  logic [DVS_W-1:0]  dvs,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_vld,
  output logic [DVD_W-1:0]  quo,
  output logic [DVS_W-1:0]  rem,
  output logic [SIDE_W-1:0] side_out
);
  localparam int NST   = (DVD_W + STEP - 1) / STEP;
  localparam int PAD_W = NST * STEP;
  localparam int REM_W = DVS_W + 1;

  // quotient bits shift into the low end as dividend bits leave the top
  logic [PAD_W-1:0]  wrk_r  [NST];
  logic [REM_W-1:0]  rem_r  [NST];
  logic [DVS_W-1:0]  dvs_r  [NST];
  logic [SIDE_W-1:0] side_r [NST];
  logic [NST-1:0]    vld_r;

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [PAD_W-1:0]  w_in;
    logic [PAD_W-1:0]  w_nxt;
    logic [REM_W-1:0]  rm_in;
    logic [REM_W-1:0]  rm_nxt;
    logic [DVS_W-1:0]  d_in;
    logic [SIDE_W-1:0] s_in;
    logic              v_in;

    if (k == 0) begin : g_first
      assign w_in  = PAD_W'(dvd);
      assign rm_in = '0;
      assign d_in  = dvs;
      assign s_in  = side_in;
      assign v_in  = in_vld;
    end else begin : g_next
      assign w_in  = wrk_r[k-1];
      assign rm_in = rem_r[k-1];
      assign d_in  = dvs_r[k-1];
      assign s_in  = side_r[k-1];
      assign v_in  = vld_r[k-1];
    end

    always_comb begin
      w_nxt  = w_in;
      rm_nxt = rm_in;
      for (int j = 0; j < STEP; j++) begin
        rm_nxt = {rm_nxt[REM_W-2:0], w_nxt[PAD_W-1]};
        w_nxt  = {w_nxt[PAD_W-2:0], 1'b0};
        if (rm_nxt >= {1'b0, d_in}) begin
          rm_nxt   = rm_nxt - {1'b0, d_in};
          w_nxt[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        wrk_r[k]  <= w_nxt;
        rem_r[k]  <= rm_nxt;
        dvs_r[k]  <= d_in;
        side_r[k] <= s_in;
      end
    end
  end

  assign out_vld  = vld_r[NST-1];
  assign quo      = wrk_r[NST-1][DVD_W-1:0];
  assign rem      = rem_r[NST-1][DVS_W-1:0];
  assign side_out = side_r[NST-1];
endmodule
`default_nettype wire

[hdl/hsa_sat.sv]
`default_nettype none
module hsa_sat (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [14:0]         s_in,
  input  hsa_pkg::hsa_carry_t carry_in,
  input  logic signed [10:0]  amount,
  input  hsa_pkg::mode_t      mode,
  output logic                out_vld,
  output logic [14:0]         s_out,
  output hsa_pkg::hsa_carry_t carry_out
);
  import hsa_pkg::*;

  localparam logic [50:0] RECIP_100 = 51'd42949672;

  logic               vld_a_r, vld_b_r, vld_c_r;
  logic signed [20:0] cand_a_r, cand_a_nxt, cand_b_r;
  logic               scale_a_r, scale_b_r;
  logic               pos_a_r, pos_b_r;
  logic [24:0]        prod_a_r, prod_b_r;
  logic [50:0]        prod2_b_r;
  hsa_carry_t         carry_a_r, carry_b_r, carry_c_r;
  logic [14:0]        s_c_r, s_c_nxt;
  logic [20:0]        amt_ext;
  logic signed [20:0] amt_q8;
  logic [18:0]        q0;
  logic [24:0]        rr;
  logic [18:0]        qd;
  logic signed [20:0] sel;

  assign amt_ext = {{10{amount[10]}}, amount};
  assign amt_q8  = $signed({amt_ext[12:0], 8'b0});

  always_comb begin
    case (mode)
      MODE_ADD: cand_a_nxt = $signed({6'b0, s_in}) + amt_q8;
      MODE_SET: cand_a_nxt = amt_q8;
      default:  cand_a_nxt = $signed({6'b0, s_in});
    endcase
  end

  // divide by 100 through a reciprocal, one correction step
  always_comb begin
    q0  = prod2_b_r[50:32];
    rr  = prod_b_r - 25'(q0) * 25'd100;
    qd  = (rr >= 25'd100) ? q0 + 19'd1 : q0;
    if (scale_b_r) begin
      sel = pos_b_r ? $signed({2'b0, qd}) : '0;
    end else begin
      sel = cand_b_r;
    end
    if (sel < 0) begin
      s_c_nxt = '0;
    end else if (sel > 21'sd25600) begin
      s_c_nxt = 15'(SAT_FULL);
    end else begin
      s_c_nxt = sel[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cand_a_r  <= cand_a_nxt;
      scale_a_r <= (mode == MODE_SCALE);
      pos_a_r   <= !amount[10] && (amount != 11'sd0);
      prod_a_r  <= 25'(s_in) * 25'(amount[9:0]);
      carry_a_r <= carry_in;
      cand_b_r  <= cand_a_r;
      scale_b_r <= scale_a_r;
      pos_b_r   <= pos_a_r;
      prod_b_r  <= prod_a_r;
      prod2_b_r <= 51'(prod_a_r) * RECIP_100;
      carry_b_r <= carry_a_r;
      s_c_r     <= s_c_nxt;
      carry_c_r <= carry_b_r;
    end
  end

  assign out_vld   = vld_c_r;
  assign s_out     = s_c_r;
  assign carry_out = carry_c_r;
endmodule
`default_nettype wire

[hdl/hsa_rgb.sv]
`default_nettype none
module hsa_rgb (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [14:0]         s_in,
  input  hsa_pkg::hsa_carry_t carry_in,
  output logic                out_vld,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  output logic [7:0]          alpha
);
  import hsa_pkg::*;

  localparam logic [28:0] K_FULL    = 29'd393216000;
  localparam logic [36:0] RECIP_625 = 37'd429496;

  logic [6:0]  vld_r;
  logic [2:0]  sec_nxt, sec1_r, sec2_r;
  logic [13:0] f_nxt, f1_r;
  logic [14:0] s1_r;
  logic [28:0] sf2_r, sg2_r, np2_r;
  logic [28:0] n3_r [3];
  logic [28:0] n3_nxt [3];
  logic [43:0] p4_r [3];
  logic [17:0] y5_r [3];
  logic [17:0] y6_r [3];
  logic [36:0] m6_r [3];
  logic [7:0]  c7_r [3];
  logic [7:0]  c7_nxt [3];
  logic [14:0] v1_r, v2_r, v3_r;
  logic [7:0]  a_r [7];
  logic [28:0] nq, nt;
  logic [48:0] x17 [3];
  logic [8:0]  q0 [3];
  logic [8:0]  qd [3];
  logic [18:0] rr [3];

  always_comb begin
    sec_nxt = '0;
    for (int k = 1; k < 6; k++) begin
      if (carry_in.hue >= 17'(k * HUE_SECT)) begin
        sec_nxt = 3'(k);
      end
    end
    f_nxt = 14'(carry_in.hue - 17'(sec_nxt) * 17'(HUE_SECT));
  end

  assign nq = K_FULL - sf2_r;
  assign nt = K_FULL - sg2_r;

  always_comb begin
    case (sec2_r)
      3'd0: begin
        n3_nxt[0] = K_FULL; n3_nxt[1] = nt;     n3_nxt[2] = np2_r;
      end
      3'd1: begin
        n3_nxt[0] = nq;     n3_nxt[1] = K_FULL; n3_nxt[2] = np2_r;
      end
      3'd2: begin
        n3_nxt[0] = np2_r;  n3_nxt[1] = K_FULL; n3_nxt[2] = nt;
      end
      3'd3: begin
        n3_nxt[0] = np2_r;  n3_nxt[1] = nq;     n3_nxt[2] = K_FULL;
      end
      3'd4: begin
        n3_nxt[0] = nt;     n3_nxt[1] = np2_r;  n3_nxt[2] = K_FULL;
      end
      default: begin
        n3_nxt[0] = K_FULL; n3_nxt[1] = np2_r;  n3_nxt[2] = nq;
      end
    endcase
  end

  // channel = floor(v * n * 17 / (625 * 2^30)), the 625 through a reciprocal
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      x17[c]    = 49'(p4_r[c]) * 49'd17;
      q0[c]     = m6_r[c][36:28];
      rr[c]     = 19'(y6_r[c]) - 19'(q0[c]) * 19'd625;
      qd[c]     = (rr[c] >= 19'd625) ? q0[c] + 9'd1 : q0[c];
      c7_nxt[c] = qd[c][8] ? 8'd255 : qd[c][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sec1_r <= sec_nxt;
      f1_r   <= f_nxt;
      s1_r   <= s_in;
      v1_r   <= carry_in.v;
      sf2_r  <= 29'(s1_r) * 29'(f1_r);
      sg2_r  <= 29'(s1_r) * 29'(15'(HUE_SECT) - 15'(f1_r));
      np2_r  <= 29'(15'(SAT_FULL) - s1_r) * 29'(HUE_SECT);
      sec2_r <= sec1_r;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      a_r[0] <= carry_in.alpha;
      for (int k = 1; k < 7; k++) begin
        a_r[k] <= a_r[k-1];
      end
      for (int c = 0; c < 3; c++) begin
        n3_r[c] <= n3_nxt[c];
        p4_r[c] <= 44'(v3_r) * 44'(n3_r[c]);
        y5_r[c] <= x17[c][47:30];
        y6_r[c] <= y5_r[c];
        m6_r[c] <= 37'(y5_r[c]) * RECIP_625;
        c7_r[c] <= c7_nxt[c];
      end
    end
  end

  assign out_vld = vld_r[6];
  assign red     = c7_r[0];
  assign green   = c7_r[1];
  assign blue    = c7_r[2];
  assign alpha   = a_r[6];
endmodule
`default_nettype wire
